// ===== rtl/dd_odo_pkg.sv =====
// Shared types, constants and the arctangent table for the wheel odometry block.
package dd_odo_pkg;

    // Shared multiplier operand and product widths.
    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;

    // Configuration port geometry and register indexes.
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_LEFT   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_RIGHT  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_TRACK = 8'd2;

    // Register reset values.
    localparam logic [15:0] RADIUS_RESET        = 16'd4719;
    localparam logic [15:0] INVERSE_TRACK_RESET = 16'd1175;

    // Radians (Q20) to binary angle scale, and the converged CORDIC gain in Q2.30.
    localparam logic [29:0]        ANGLE_SCALE = 30'd683565276;
    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

    // Arctangent table geometry.
    localparam int TAB_DEPTH = 30;
    localparam int TAB_IDX_W = 5;

    // Result bundle handed from the CORDIC unit to the sequencer.
    typedef struct packed {
        logic               done;
        logic signed [31:0] cos_val;
        logic signed [31:0] sin_val;
    } cordic_result_t;

    // Arctangent of 2^-i as a binary angle, full circle equals 2^32.
    function automatic logic [29:0] atan_lookup(input logic [TAB_IDX_W-1:0] idx);
        logic [29:0] val;
        case (idx)
            5'd0:    val = 30'd536870912;
            5'd1:    val = 30'd316933406;
            5'd2:    val = 30'd167458907;
            5'd3:    val = 30'd85004756;
            5'd4:    val = 30'd42667331;
            5'd5:    val = 30'd21354465;
            5'd6:    val = 30'd10679838;
            5'd7:    val = 30'd5340245;
            5'd8:    val = 30'd2670163;
            5'd9:    val = 30'd1335087;
            5'd10:   val = 30'd667544;
            5'd11:   val = 30'd333772;
            5'd12:   val = 30'd166886;
            5'd13:   val = 30'd83443;
            5'd14:   val = 30'd41722;
            5'd15:   val = 30'd20861;
            5'd16:   val = 30'd10430;
            5'd17:   val = 30'd5215;
            5'd18:   val = 30'd2608;
            5'd19:   val = 30'd1304;
            5'd20:   val = 30'd652;
            5'd21:   val = 30'd326;
            5'd22:   val = 30'd163;
            5'd23:   val = 30'd81;
            5'd24:   val = 30'd41;
            5'd25:   val = 30'd20;
            5'd26:   val = 30'd10;
            5'd27:   val = 30'd5;
            5'd28:   val = 30'd3;
            5'd29:   val = 30'd1;
            default: val = 30'd0;
        endcase
        return val;
    endfunction

endpackage

// ===== rtl/differential_drive_odometry.sv =====
// Top level of the differential-drive wheel odometry block: sequencer and pose state.
// Each accepted transaction carries one pair of wheel angle increments and yields exactly
// one pose transaction: the saturating Q16.16 position and the wrapping 32-bit heading after
// a midpoint update. The block takes one transaction at a time and is ready again once the
// previous pose has been loaded into the output register. The pace is set by the CORDIC
// unit, which performs one micro-rotation per cycle, and by the single shared multiplier,
// which forms the six products of an update one after another.
// A finished pose sits in the output register while the next increments are taken in.
// Configuration writes are always accepted and should be issued only while no update is
// in flight.
module differential_drive_odometry
    import dd_odo_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [15:0]    delta_left,
    input  logic signed [15:0]    delta_right,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [31:0]    pose_east,
    output logic signed [31:0]    pose_north,
    output logic [31:0]           heading_out
);

    typedef enum logic [3:0] {
        IDLE,
        MUL_LEFT,
        MUL_RIGHT,
        SUM_DIF,
        MUL_TRACK,
        MUL_ANGLE,
        MID_ANGLE,
        CORDIC_GO,
        CORDIC_WAIT,
        MUL_EAST,
        MUL_NORTH,
        NORTH_HEAD,
        OUTPUT
    } state_t;

    state_t state_reg;

    logic [15:0]              radius_left_reg;
    logic [15:0]              radius_right_reg;
    logic [15:0]              inverse_track_reg;
    logic signed [31:0]       position_x_reg;
    logic signed [31:0]       position_y_reg;
    logic [31:0]              heading_reg;

    logic signed [15:0]       delta_left_reg;
    logic signed [15:0]       delta_right_reg;
    logic signed [31:0]       scaled_left_reg;
    logic signed [32:0]       sum_reg;
    logic signed [32:0]       dif_reg;
    logic [31:0]              full_reg;
    logic [31:0]              mid_reg;
    logic signed [31:0]       cos_reg;
    logic signed [31:0]       sin_reg;

    logic                     out_valid_reg;
    logic signed [31:0]       pose_east_reg;
    logic signed [31:0]       pose_north_reg;
    logic [31:0]              heading_out_reg;

    logic signed [MUL_W-1:0]  op_a;
    logic signed [MUL_W-1:0]  op_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [31:0]       scaled_right;
    logic signed [32:0]       rate_q20;
    logic                     cordic_start;
    cordic_result_t           cordic_res;
    logic                     out_free;

    // Saturating add of a position step to a Q16.16 coordinate.
    function automatic logic signed [31:0] sat_add(input logic signed [31:0] pos,
                                                   input logic signed [21:0] step);
        logic signed [32:0] total;
        logic signed [31:0] res;
        total = $signed({pos[31], pos}) + 33'(step);
        if (total[32] != total[31])
        begin
            res = total[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            res = total[31:0];
        end
        return res;
    endfunction

    assign scaled_right = prod[31:0];
    assign rate_q20     = prod[48:16];
    assign cordic_start = (state_reg == CORDIC_GO);
    assign out_free     = !out_valid_reg || out_ready;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (state_reg)
            MUL_LEFT:
            begin
                op_a = $signed(MUL_W'(radius_left_reg));
                op_b = MUL_W'(delta_left_reg);
            end
            MUL_RIGHT:
            begin
                op_a = $signed(MUL_W'(radius_right_reg));
                op_b = MUL_W'(delta_right_reg);
            end
            MUL_TRACK:
            begin
                op_a = MUL_W'(dif_reg);
                op_b = $signed(MUL_W'(inverse_track_reg));
            end
            MUL_ANGLE:
            begin
                op_a = MUL_W'(rate_q20);
                op_b = $signed(MUL_W'(ANGLE_SCALE));
            end
            MUL_EAST:
            begin
                op_a = MUL_W'(sum_reg);
                op_b = MUL_W'(cos_reg);
            end
            MUL_NORTH:
            begin
                op_a = MUL_W'(sum_reg);
                op_b = MUL_W'(sin_reg);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    dd_odo_mul u_mul (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    dd_odo_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cordic_start),
        .angle  (mid_reg),
        .result (cordic_res)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_left_reg   <= RADIUS_RESET;
            radius_right_reg  <= RADIUS_RESET;
            inverse_track_reg <= INVERSE_TRACK_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_RADIUS_LEFT:   radius_left_reg   <= cfg_data;
                CFG_RADIUS_RIGHT:  radius_right_reg  <= cfg_data;
                CFG_INVERSE_TRACK: inverse_track_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Sequencer, pose state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= IDLE;
            position_x_reg <= '0;
            position_y_reg <= '0;
            heading_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (state_reg == OUTPUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= MUL_LEFT;
                    end
                end
                MUL_LEFT:    state_reg <= MUL_RIGHT;
                MUL_RIGHT:   state_reg <= SUM_DIF;
                SUM_DIF:     state_reg <= MUL_TRACK;
                MUL_TRACK:   state_reg <= MUL_ANGLE;
                MUL_ANGLE:   state_reg <= MID_ANGLE;
                MID_ANGLE:   state_reg <= CORDIC_GO;
                CORDIC_GO:   state_reg <= CORDIC_WAIT;
                CORDIC_WAIT:
                begin
                    if (cordic_res.done)
                    begin
                        state_reg <= MUL_EAST;
                    end
                end
                MUL_EAST:    state_reg <= MUL_NORTH;
                MUL_NORTH:
                begin
                    position_x_reg <= sat_add(position_x_reg, prod[64:43]);
                    state_reg      <= NORTH_HEAD;
                end
                NORTH_HEAD:
                begin
                    position_y_reg <= sat_add(position_y_reg, prod[64:43]);
                    heading_reg    <= heading_reg + full_reg;
                    state_reg      <= OUTPUT;
                end
                OUTPUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= IDLE;
                    end
                end
                default:     state_reg <= IDLE;
            endcase
        end
    end

    // Datapath registers loaded along the sequence.
    always_ff @(posedge clk)
    begin
        if (state_reg == IDLE && in_valid)
        begin
            delta_left_reg  <= delta_left;
            delta_right_reg <= delta_right;
        end
        if (state_reg == MUL_RIGHT)
        begin
            scaled_left_reg <= prod[31:0];
        end
        if (state_reg == SUM_DIF)
        begin
            sum_reg <= 33'(scaled_left_reg) + 33'(scaled_right);
            dif_reg <= 33'(scaled_left_reg) - 33'(scaled_right);
        end
        if (state_reg == MID_ANGLE)
        begin
            full_reg <= prod[51:20];
            mid_reg  <= heading_reg + prod[52:21];
        end
        if (state_reg == CORDIC_WAIT && cordic_res.done)
        begin
            cos_reg <= cordic_res.cos_val;
            sin_reg <= cordic_res.sin_val;
        end
        if (state_reg == OUTPUT && out_free)
        begin
            pose_east_reg   <= position_x_reg;
            pose_north_reg  <= position_y_reg;
            heading_out_reg <= heading_reg;
        end
    end

    assign cfg_ready   = 1'b1;
    assign in_ready    = (state_reg == IDLE);
    assign out_valid   = out_valid_reg;
    assign pose_east   = pose_east_reg;
    assign pose_north  = pose_north_reg;
    assign heading_out = heading_out_reg;

    // An accepted transaction always starts the multiply sequence.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == MUL_LEFT))
        else $error("accepted transaction did not start the sequence");

    // The CORDIC unit finishes only while the sequencer waits for it.
    a_cordic_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        cordic_res.done |-> (state_reg == CORDIC_WAIT))
        else $error("CORDIC result arrived outside the wait state");

    // The heading moves only in the state that commits it.
    a_heading_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != NORTH_HEAD) |=> $stable(heading_reg))
        else $error("heading changed outside its commit state");

    // A new pose transaction appears only when leaving the output state.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == OUTPUT))
        else $error("pose transaction raised outside the output state");

endmodule

// ===== rtl/dd_odo_mul.sv =====
// Shared signed multiplier with a registered product.
module dd_odo_mul
    import dd_odo_pkg::*;
(
    input  logic                     clk,
    input  logic signed [MUL_W-1:0]  op_a,
    input  logic signed [MUL_W-1:0]  op_b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    // The product is registered every cycle; the sequencer reads it in the next state.
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/dd_odo_cordic.sv =====
// Iterative rotation-mode CORDIC giving cosine and sine of a binary angle.
module dd_odo_cordic
    import dd_odo_pkg::*;
#(
    parameter int STEPS = 16
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [31:0]    angle,
    output cordic_result_t result
);

    localparam int ITER_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic                busy_reg;
    logic                done_reg;
    logic                flip_reg;
    logic [ITER_W-1:0]   iter_reg;
    logic signed [31:0]  x_reg;
    logic signed [31:0]  y_reg;
    logic signed [32:0]  z_reg;

    logic                flip_start;
    logic [31:0]         angle_folded;
    logic signed [31:0]  x_shift;
    logic signed [31:0]  y_shift;
    logic signed [32:0]  atan_val;

    // Angles within a quarter turn of pi are folded by a half turn.
    assign flip_start   = angle[31] ^ angle[30];
    assign angle_folded = flip_start ? (angle ^ 32'h8000_0000) : angle;

    // One micro-rotation per cycle through the shared shifters and adders.
    assign x_shift  = x_reg >>> iter_reg;
    assign y_shift  = y_reg >>> iter_reg;
    assign atan_val = $signed({3'b000, atan_lookup(TAB_IDX_W'(iter_reg))});

    // Control and datapath of the iteration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            flip_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (iter_reg == ITER_W'(STEPS - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                flip_reg <= flip_start;
                iter_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (iter_reg == ITER_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    iter_reg <= iter_reg + 1'b1;
                end
            end
        end
    end

    // Vector and residual angle registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= CORDIC_GAIN;
            y_reg <= '0;
            z_reg <= $signed({angle_folded[31], angle_folded});
        end
        else if (busy_reg)
        begin
            if (!z_reg[32])
            begin
                x_reg <= x_reg - y_shift;
                y_reg <= y_reg + x_shift;
                z_reg <= z_reg - atan_val;
            end
            else
            begin
                x_reg <= x_reg + y_shift;
                y_reg <= y_reg - x_shift;
                z_reg <= z_reg + atan_val;
            end
        end
    end

    // Undo the half-turn fold by negating both results.
    assign result.done    = done_reg;
    assign result.cos_val = flip_reg ? -x_reg : x_reg;
    assign result.sin_val = flip_reg ? -y_reg : y_reg;

endmodule

// ===== tb/tb_differential_drive_odometry.sv =====
// Self-checking testbench for the differential-drive odometry block with a fixed-point pose predictor.
module tb_differential_drive_odometry;
    import dd_odo_pkg::*;

    // Build constants for the block and the pose predictor.
    localparam int ROTATIONS = 16;
    localparam longint RAD_TO_BAM = 64'sd683565276;
    localparam longint CORDIC_START = 64'sd652032874;
    localparam longint POS_MAX = 64'sd2147483647;
    localparam longint POS_MIN = -64'sd2147483648;
    localparam longint ATAN_BAM [30] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
        5, 3, 1
    };

    // Register indexes past the end of the map, which the block must ignore.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LOW  = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HIGH = 8'hFF;

    // Run control: receiver hold-off, quiet-cycle limit and the settle time at the end.
    localparam int HOLD_AT      = 170;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 2000;
    localparam int SETTLE_TIME  = 60;
    localparam logic signed [15:0] EXTREME_DELTAS [4] = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1};

    typedef struct {
        logic [31:0] east;
        logic [31:0] north;
        logic [31:0] heading;
    } pose_t;

    // Scoreboard that tracks the expected pose stream and compares the block output against it.
    class pose_scoreboard;
        longint radius_l;
        longint radius_r;
        longint inv_track;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [31:0] heading;
        pose_t poses_due[$];
        int failures;
        int reports;

        function new();
            radius_l = RADIUS_RESET;
            radius_r = RADIUS_RESET;
            inv_track = INVERSE_TRACK_RESET;
            pos_x = '0;
            pos_y = '0;
            heading = '0;
            failures = 0;
            reports = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_RADIUS_LEFT:   radius_l = val;
                CFG_RADIUS_RIGHT:  radius_r = val;
                CFG_INVERSE_TRACK: inv_track = val;
                default: ;
            endcase
        endfunction

        // Rotation-mode CORDIC in Q2.30; angles in the far half turn are folded by pi.
        function void rotate(input logic [31:0] angle, output longint cos_q, output longint sin_q);
            logic [31:0] a;
            logic [31:0] probe;
            longint x, y, z, t;
            a = angle;
            probe = a + 32'h4000_0000;
            if (probe[31])
                a = a - 32'h8000_0000;
            z = longint'($signed(a));
            x = CORDIC_START;
            y = 0;
            for (int i = 0; i < ROTATIONS; i++)
            begin
                if (z >= 0)
                begin
                    t = x - (y >>> i);
                    y = y + (x >>> i);
                    z = z - ATAN_BAM[i];
                end
                else
                begin
                    t = x + (y >>> i);
                    y = y - (x >>> i);
                    z = z + ATAN_BAM[i];
                end
                x = t;
            end
            cos_q = probe[31] ? -x : x;
            sin_q = probe[31] ? -y : y;
        endfunction

        function longint clamp32(longint v);
            if (v > POS_MAX)
                return POS_MAX;
            if (v < POS_MIN)
                return POS_MIN;
            return v;
        endfunction

        // Advance the predicted pose by one pair of wheel increments and queue the result.
        function void note_increments(logic signed [15:0] dl, logic signed [15:0] dr);
            longint scaled_l, scaled_r, travel, spread, rad_q20, turn, c, s;
            logic [31:0] full_turn;
            logic [31:0] half_turn;
            scaled_l = radius_l * longint'(dl);
            scaled_r = radius_r * longint'(dr);
            travel = scaled_l + scaled_r;
            spread = scaled_l - scaled_r;
            rad_q20 = (spread * inv_track) >>> 16;
            turn = rad_q20 * RAD_TO_BAM;
            full_turn = 32'(turn >>> 20);
            half_turn = 32'(turn >>> 21);
            rotate(heading + half_turn, c, s);
            pos_x = 32'(clamp32(longint'(pos_x) + ((travel * c) >>> 43)));
            pos_y = 32'(clamp32(longint'(pos_y) + ((travel * s) >>> 43)));
            heading = heading + full_turn;
            poses_due.push_back('{pos_x, pos_y, heading});
        endfunction

        // Compare one pose transaction from the block against the oldest expectation.
        function void check_pose(logic [31:0] east, logic [31:0] north, logic [31:0] hdg);
            pose_t want;
            if (poses_due.size() == 0)
            begin
                failures++;
                if (reports < 10)
                    $display("pose with nothing expected: east %h north %h heading %h",
                             east, north, hdg);
                reports++;
                return;
            end
            want = poses_due.pop_front();
            if (want.east !== east || want.north !== north || want.heading !== hdg)
            begin
                failures++;
                if (reports < 10)
                    $display("pose mismatch: east %h/%h north %h/%h heading %h/%h (exp/got)",
                             want.east, east, want.north, north, want.heading, hdg);
                reports++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [15:0] delta_left = '0;
    logic signed [15:0] delta_right = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] pose_east;
    logic signed [31:0] pose_north;
    logic [31:0] heading_out;

    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;
    bit rx_hurry = 1'b0;
    int quiet_cycles = 0;
    pose_scoreboard sb = new();

    differential_drive_odometry #(.CORDIC_STEPS(ROTATIONS)) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .delta_left  (delta_left),
        .delta_right (delta_right),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pose_east   (pose_east),
        .pose_north  (pose_north),
        .heading_out (heading_out)
    );

    // Clock with a period of two time units.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Every accepted pose transaction is checked on the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_pose(pose_east, pose_north, heading_out);
    end

    // Watchdog: the run ends when no transaction of any kind happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Pose receiver: random stalls, calm stretches, and one long hold-off to back up the block.
    initial
    begin : pose_sink
        int stall;
        int taken;
        taken = 0;
        @(posedge rst_n);
        forever
        begin
            if (taken % 40 == 0)
                rx_calm = ($urandom_range(0, 3) == 0);
            stall = (rx_calm || rx_hurry) ? 0 : $urandom_range(0, 19);
            if (taken == HOLD_AT)
                stall = HOLD_CYCLES;
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            taken++;
        end
    end

    function automatic logic [15:0] draw_register();
        case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Offer one pair of increments after a random gap and wait for the transaction.
    task automatic offer_increments(input logic signed [15:0] dl, input logic signed [15:0] dr);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 19);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        delta_left <= dl;
        delta_right <= dr;
        do @(posedge clk); while (!in_ready);
        sb.note_increments(dl, dr);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.write_register(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Stop offering input and wait until every expected pose has come back.
    task automatic quiesce();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.poses_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_geometry(input logic [15:0] rl, input logic [15:0] rr, input logic [15:0] it);
        quiesce();
        write_register(CFG_RADIUS_LEFT, rl);
        write_register(CFG_RADIUS_RIGHT, rr);
        write_register(CFG_INVERSE_TRACK, it);
    endtask

    // Random increments: full-range noise, straight driving, gentle turns and field extremes.
    task automatic drive_random(input int count);
        logic signed [15:0] dl, dr;
        int base;
        for (int k = 0; k < count; k++)
        begin
            if (k % 25 == 0)
                tx_calm = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
                0:
                begin
                    dl = 16'($urandom);
                    dr = 16'($urandom);
                end
                1:
                begin
                    base = $urandom_range(0, 1200) - 600;
                    dl = 16'(base);
                    dr = 16'(base + $urandom_range(0, 40) - 20);
                end
                2:
                begin
                    dl = 16'($urandom_range(0, 1200) - 600);
                    dr = 16'($urandom_range(0, 1200) - 600);
                end
                default:
                begin
                    dl = EXTREME_DELTAS[$urandom_range(0, 3)];
                    dr = EXTREME_DELTAS[$urandom_range(0, 3)];
                end
            endcase
            offer_increments(dl, dr);
        end
    endtask

    // Main sequence: reset, directed cases, randomized phases, a spin, then a full-speed stretch and a random tail.
    initial
    begin : stimulus
        int guard;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Field extremes and turn direction at the reset geometry.
        offer_increments(16'sd0, 16'sd0);
        offer_increments(16'sd32767, 16'sd32767);
        offer_increments(-16'sd32768, -16'sd32768);
        offer_increments(16'sd32767, -16'sd32768);
        offer_increments(-16'sd32768, 16'sd32767);
        offer_increments(16'sd4096, 16'sd1024);
        offer_increments(16'sd1024, 16'sd4096);
        offer_increments(-16'sd1, -16'sd1);
        offer_increments(16'sd1, 16'sd0);
        offer_increments(16'sh5555, -16'sh5556);
        offer_increments(-16'sh5556, 16'sh5555);

        // With the left wheel radius at zero, only the right wheel adds travel and turn.
        set_geometry(16'd0, RADIUS_RESET, INVERSE_TRACK_RESET);
        offer_increments(16'sd4096, 16'sd4096);
        offer_increments(-16'sd32768, 16'sd32767);

        // Zero inverse track freezes the heading.
        set_geometry(RADIUS_RESET, RADIUS_RESET, 16'd0);
        offer_increments(16'sd32767, -16'sd32768);
        offer_increments(16'sd100, -16'sd100);

        // Writes to indexes past the register map change nothing.
        quiesce();
        write_register(CFG_UNUSED_LOW, 16'hFFFF);
        write_register(CFG_UNUSED_HIGH, 16'h0000);
        offer_increments(16'sd2000, -16'sd500);

        // Largest geometry turns the heading through many full circles.
        set_geometry(16'hFFFF, 16'hFFFF, 16'hFFFF);
        offer_increments(16'sd32767, -16'sd32768);
        offer_increments(-16'sd32768, 16'sd32767);

        // Randomized phases, each under its own register setting.
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: set_geometry(RADIUS_RESET, RADIUS_RESET, INVERSE_TRACK_RESET);
                1: set_geometry(16'hFFFF, 16'hFFFF, 16'hFFFF);
                2: set_geometry(16'h0000, 16'h0000, 16'h0000);
                3: set_geometry(16'h0001, 16'hFFFF, 16'h0100);
                default: set_geometry(draw_register(), draw_register(), draw_register());
            endcase
            if (p == 4)
                write_register(CFG_UNUSED_HIGH, 16'($urandom));
            drive_random(90);
        end

        // Spin in place until the heading points roughly south-east.
        tx_calm = 1'b0;
        set_geometry(RADIUS_RESET, RADIUS_RESET, INVERSE_TRACK_RESET);
        guard = 0;
        while (!(sb.heading >= 32'hD555_5556 && sb.heading <= 32'hEAAA_AAAB) && guard < 40)
        begin
            offer_increments(-16'sd2000, 16'sd2000);
            guard++;
        end

        // Drive flat out on that heading for a stretch of full-scale steps.
        set_geometry(16'hFFFF, 16'hFFFF, 16'h0000);
        tx_calm = 1'b1;
        rx_hurry = 1'b1;
        repeat (60) offer_increments(16'sd32767, 16'sd32767);
        rx_hurry = 1'b0;
        tx_calm = 1'b0;
        drive_random(20);

        // Drain and let the block settle before the verdict.
        quiesce();
        repeat (SETTLE_TIME) @(posedge clk);
        if (sb.failures == 0 && sb.poses_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
